[design/lspg_pkg.sv]
// Shared types and constants for the lidar sector proximity gate.
`default_nettype none
package lspg_pkg;

	// Point coordinate width in bits (two's complement millimetres).
	localparam int COORD_WIDTH = 16;
	// Width of the distance limit register.
	localparam int LIM_W = 15;
	// Width of the sine limit register (Q1.15).
	localparam int SINE_W = 16;
	// Width used to compare coordinate magnitudes against the limit.
	localparam int MAG_W = (COORD_WIDTH > LIM_W) ? COORD_WIDTH : LIM_W;

	// Stream payload widths, padded to whole bytes.
	localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_W = 8;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_DISTANCE_LIMIT = 1'b0;
	localparam logic REG_SINE_LIMIT = 1'b1;
	localparam logic [LIM_W-1:0] DISTANCE_LIMIT_RST = 15'd200;
	localparam logic [SINE_W-1:0] SINE_LIMIT_RST = 16'd3993;

	// Digit-serial multiplier geometry.
	localparam int OPND_W = 32;
	localparam int DIG_W = 4;
	localparam int PART_W = OPND_W + DIG_W;
	localparam int PROD_W = 2 * OPND_W;
	localparam int SHORT_DIGITS = 4;
	localparam int LONG_DIGITS = OPND_W / DIG_W;
	localparam int DIG_CNT_W = $clog2(LONG_DIGITS);
	// Bits of the product that a short run leaves in the low register.
	localparam int SHORT_LO_W = SHORT_DIGITS * DIG_W;

	// Request and status between the sequencer and the multiplier.
	typedef struct packed {
		logic start;
		logic long_op;
	} mul_req_t;

	typedef struct packed {
		logic done;
	} mul_rsp_t;

	// Request and status between the top level and the point judge.
	typedef struct packed {
		logic start;
	} judge_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} judge_rsp_t;

endpackage
`default_nettype wire

[design/lspg_serial_mul.sv]
// Digit-serial unsigned multiplier, one 4-bit digit of the multiplier per cycle.
`default_nettype none
module lspg_serial_mul (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lspg_pkg::mul_req_t             req,
	input  wire logic [lspg_pkg::OPND_W-1:0]    opnd_a,
	input  wire logic [lspg_pkg::OPND_W-1:0]    opnd_b,
	output lspg_pkg::mul_rsp_t                  rsp,
	output logic [lspg_pkg::PROD_W-1:0]         product
);

	logic [lspg_pkg::OPND_W-1:0]    a_q;
	logic [lspg_pkg::OPND_W-1:0]    b_q;
	logic [lspg_pkg::OPND_W-1:0]    hi_q;
	logic [lspg_pkg::OPND_W-1:0]    lo_q;
	logic [lspg_pkg::DIG_CNT_W-1:0] cnt_q;
	logic                           long_q;
	logic                           busy_q;
	logic                           done_q;
	logic [lspg_pkg::PART_W-1:0]    part;
	logic [lspg_pkg::PART_W-1:0]    sum;

	// One partial product per cycle, added to the running high half.
	assign part = lspg_pkg::PART_W'(a_q) * lspg_pkg::PART_W'(b_q[lspg_pkg::DIG_W-1:0]);
	assign sum = part + lspg_pkg::PART_W'(hi_q);

	// The accumulator shifts right a digit per step, so the adder stays narrow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			cnt_q <= '0;
			long_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q <= opnd_a;
				b_q <= opnd_b;
				hi_q <= '0;
				lo_q <= '0;
				long_q <= req.long_op;
				cnt_q <= req.long_op ? lspg_pkg::DIG_CNT_W'(lspg_pkg::LONG_DIGITS - 1)
				                     : lspg_pkg::DIG_CNT_W'(lspg_pkg::SHORT_DIGITS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				hi_q <= sum[lspg_pkg::PART_W-1:lspg_pkg::DIG_W];
				lo_q <= {sum[lspg_pkg::DIG_W-1:0], lo_q[lspg_pkg::OPND_W-1:lspg_pkg::DIG_W]};
				b_q <= b_q >> lspg_pkg::DIG_W;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A short run leaves only its top digits in the low register.
	always_comb begin
		if (long_q) begin
			product = {hi_q, lo_q};
		end else begin
			product = {{(lspg_pkg::PROD_W - lspg_pkg::OPND_W - lspg_pkg::SHORT_LO_W){1'b0}},
			           hi_q, lo_q[lspg_pkg::OPND_W-1:lspg_pkg::OPND_W-lspg_pkg::SHORT_LO_W]};
		end
	end

	assign rsp.done = done_q;

endmodule
`default_nettype wire

[design/lspg_point_judge.sv]
// Point judge: range prechecks, then squares and products on the serial multiplier.
`default_nettype none
module lspg_point_judge (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lspg_pkg::judge_req_t              req,
	input  wire logic [lspg_pkg::COORD_WIDTH-1:0]  pos_x,
	input  wire logic [lspg_pkg::COORD_WIDTH-1:0]  pos_y,
	input  wire logic [lspg_pkg::COORD_WIDTH-1:0]  pos_z,
	input  wire logic [lspg_pkg::LIM_W-1:0]        distance_limit,
	input  wire logic [lspg_pkg::SINE_W-1:0]       sine_limit,
	output lspg_pkg::judge_rsp_t                   rsp
);

	typedef enum logic [1:0] {J_IDLE, J_ISSUE, J_WAIT} jstate_t;
	typedef enum logic [2:0] {OP_XX, OP_YY, OP_ZZ, OP_LL, OP_SS, OP_RHS} op_t;

	jstate_t                        jst_q;
	op_t                            op_q;
	logic [lspg_pkg::LIM_W-1:0]     ax_q;
	logic [lspg_pkg::LIM_W-1:0]     ay_q;
	logic [lspg_pkg::LIM_W-1:0]     az_q;
	logic [lspg_pkg::OPND_W-1:0]    d2_q;
	logic [2*lspg_pkg::LIM_W-1:0]   az2_q;
	logic [lspg_pkg::OPND_W-1:0]    s2_q;
	logic                           done_q;
	logic                           hit_q;
	logic [lspg_pkg::MAG_W-1:0]     ax;
	logic [lspg_pkg::MAG_W-1:0]     ay;
	logic [lspg_pkg::MAG_W-1:0]     az;
	logic [lspg_pkg::MAG_W-1:0]     lim_ext;
	logic                           pre_ok;
	logic [lspg_pkg::PROD_W-1:0]    lhs;
	lspg_pkg::mul_req_t             mreq;
	lspg_pkg::mul_rsp_t             mrsp;
	logic [lspg_pkg::OPND_W-1:0]    opnd_a;
	logic [lspg_pkg::OPND_W-1:0]    opnd_b;
	logic [lspg_pkg::PROD_W-1:0]    product;

	// Magnitude of a two's complement coordinate.
	function automatic logic [lspg_pkg::MAG_W-1:0] coord_mag(
		input logic [lspg_pkg::COORD_WIDTH-1:0] v
	);
		logic [lspg_pkg::COORD_WIDTH-1:0] n;
		n = v[lspg_pkg::COORD_WIDTH-1] ? (~v + 1'b1) : v;
		return lspg_pkg::MAG_W'(n);
	endfunction

	// Prechecks: x forward and within the limit, y and z strictly inside it.
	assign ax = coord_mag(pos_x);
	assign ay = coord_mag(pos_y);
	assign az = coord_mag(pos_z);
	assign lim_ext = lspg_pkg::MAG_W'(distance_limit);
	assign pre_ok = !pos_x[lspg_pkg::COORD_WIDTH-1] && (ax != '0) && (ax <= lim_ext)
	              && (ay < lim_ext) && (az < lim_ext);

	// Pitch band: z squared times 2^30 against sine squared times range squared.
	assign lhs = {{(lspg_pkg::PROD_W - 2*lspg_pkg::LIM_W - 30){1'b0}}, az2_q, 30'd0};

	// Operand selection for the current product.
	always_comb begin
		opnd_a = '0;
		opnd_b = '0;
		unique case (op_q)
			OP_XX: begin
				opnd_a = lspg_pkg::OPND_W'(ax_q);
				opnd_b = lspg_pkg::OPND_W'(ax_q);
			end
			OP_YY: begin
				opnd_a = lspg_pkg::OPND_W'(ay_q);
				opnd_b = lspg_pkg::OPND_W'(ay_q);
			end
			OP_ZZ: begin
				opnd_a = lspg_pkg::OPND_W'(az_q);
				opnd_b = lspg_pkg::OPND_W'(az_q);
			end
			OP_LL: begin
				opnd_a = lspg_pkg::OPND_W'(distance_limit);
				opnd_b = lspg_pkg::OPND_W'(distance_limit);
			end
			OP_SS: begin
				opnd_a = lspg_pkg::OPND_W'(sine_limit);
				opnd_b = lspg_pkg::OPND_W'(sine_limit);
			end
			OP_RHS: begin
				opnd_a = s2_q;
				opnd_b = d2_q;
			end
			default: begin
				opnd_a = '0;
				opnd_b = '0;
			end
		endcase
	end

	assign mreq.start = (jst_q == J_ISSUE);
	assign mreq.long_op = (op_q == OP_RHS);

	lspg_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.opnd_a  (opnd_a),
		.opnd_b  (opnd_b),
		.rsp     (mrsp),
		.product (product)
	);

	// Sequencer: one product at a time, early exit when the range test fails.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jst_q <= J_IDLE;
			op_q <= OP_XX;
			ax_q <= '0;
			ay_q <= '0;
			az_q <= '0;
			d2_q <= '0;
			az2_q <= '0;
			s2_q <= '0;
			done_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (jst_q)
				J_IDLE: begin
					if (req.start) begin
						if (pre_ok) begin
							ax_q <= ax[lspg_pkg::LIM_W-1:0];
							ay_q <= ay[lspg_pkg::LIM_W-1:0];
							az_q <= az[lspg_pkg::LIM_W-1:0];
							op_q <= OP_XX;
							jst_q <= J_ISSUE;
						end else begin
							hit_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
				J_ISSUE: begin
					jst_q <= J_WAIT;
				end
				J_WAIT: begin
					if (mrsp.done) begin
						jst_q <= J_ISSUE;
						unique case (op_q)
							OP_XX: begin
								d2_q <= product[lspg_pkg::OPND_W-1:0];
								op_q <= OP_YY;
							end
							OP_YY: begin
								d2_q <= d2_q + product[lspg_pkg::OPND_W-1:0];
								op_q <= OP_ZZ;
							end
							OP_ZZ: begin
								d2_q <= d2_q + product[lspg_pkg::OPND_W-1:0];
								az2_q <= product[2*lspg_pkg::LIM_W-1:0];
								op_q <= OP_LL;
							end
							OP_LL: begin
								if (d2_q >= product[lspg_pkg::OPND_W-1:0]) begin
									hit_q <= 1'b0;
									done_q <= 1'b1;
									jst_q <= J_IDLE;
								end else begin
									op_q <= OP_SS;
								end
							end
							OP_SS: begin
								s2_q <= product[lspg_pkg::OPND_W-1:0];
								op_q <= OP_RHS;
							end
							OP_RHS: begin
								hit_q <= (lhs <= product);
								done_q <= 1'b1;
								jst_q <= J_IDLE;
							end
							default: begin
								jst_q <= J_IDLE;
							end
						endcase
					end
				end
				default: begin
					jst_q <= J_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.hit = hit_q;

endmodule
`default_nettype wire

[design/lidar_sector_proximity_gate.sv]
// Top level: stream ports, configuration registers, frame flags and result register.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  s_tdata = pos_x, pos_y, pos_z; s_tuser = point_valid;
//                                           s_tlast = last_point
//   m_*       out        m_tvalid/m_tready  m_tdata = collision
//   APB       in         psel/penable       distance_limit at 0x0, sine_limit at 0x4
//
// A point that reaches the pitch test runs six products on one digit-serial multiplier:
// a short run for each 16-bit operand and a long run for the final one. A point that
// fails the range test stops after four products, one rejected by the coordinate checks
// never uses the multiplier, and a point marked not valid skips the judge. Reset clears
// the frame flags and the result register; the limits return to 200 mm and 3993. A closing
// point of a frame with a valid point waits while an earlier result has not been taken.
`default_nettype none
module lidar_sector_proximity_gate (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input stream.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// pos_x [15:0], pos_y [31:16], pos_z [47:32]
	input  wire logic [lspg_pkg::TDATA_W-1:0]  s_tdata,
	// point_valid [0]
	input  wire logic [0:0]                    s_tuser,
	input  wire logic                          s_tlast,
	// Result stream.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// collision [0]
	output logic [lspg_pkg::OUT_W-1:0]         m_tdata,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lspg_pkg::APB_AW-1:0]   paddr,
	input  wire logic [lspg_pkg::APB_DW-1:0]   pwdata,
	output logic [lspg_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);

	typedef enum logic [1:0] {ST_IDLE, ST_JUDGE, ST_CLOSE} state_t;

	state_t                          state_q;
	logic                            last_q;
	logic                            hit_seen_q;
	logic                            valid_seen_q;
	logic                            m_tvalid_q;
	logic                            collision_q;
	logic [lspg_pkg::LIM_W-1:0]      distance_limit_q;
	logic [lspg_pkg::SINE_W-1:0]     sine_limit_q;
	logic                            accept;
	logic                            out_free;
	logic                            close_go;
	logic                            out_load;
	logic                            cfg_write;
	lspg_pkg::judge_req_t            jreq;
	lspg_pkg::judge_rsp_t            jrsp;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_limit_q <= lspg_pkg::DISTANCE_LIMIT_RST;
			sine_limit_q <= lspg_pkg::SINE_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				lspg_pkg::REG_DISTANCE_LIMIT: distance_limit_q <= pwdata[lspg_pkg::LIM_W-1:0];
				lspg_pkg::REG_SINE_LIMIT:     sine_limit_q <= pwdata[lspg_pkg::SINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lspg_pkg::REG_DISTANCE_LIMIT: prdata = lspg_pkg::APB_DW'(distance_limit_q);
			lspg_pkg::REG_SINE_LIMIT:     prdata = lspg_pkg::APB_DW'(sine_limit_q);
			default:                      prdata = '0;
		endcase
	end

	// Handshake and frame close conditions.
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign close_go = (state_q == ST_CLOSE) && (!last_q || !valid_seen_q || out_free);
	assign out_load = close_go && last_q && valid_seen_q;
	assign jreq.start = accept && s_tuser[0];

	lspg_point_judge u_judge (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (jreq),
		.pos_x          (s_tdata[lspg_pkg::COORD_WIDTH-1:0]),
		.pos_y          (s_tdata[2*lspg_pkg::COORD_WIDTH-1:lspg_pkg::COORD_WIDTH]),
		.pos_z          (s_tdata[3*lspg_pkg::COORD_WIDTH-1:2*lspg_pkg::COORD_WIDTH]),
		.distance_limit (distance_limit_q),
		.sine_limit     (sine_limit_q),
		.rsp            (jrsp)
	);

	// Frame state, sticky flags and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q <= 1'b0;
			hit_seen_q <= 1'b0;
			valid_seen_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			collision_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= s_tlast;
						state_q <= s_tuser[0] ? ST_JUDGE : ST_CLOSE;
					end
				end
				ST_JUDGE: begin
					if (jrsp.done) begin
						valid_seen_q <= 1'b1;
						hit_seen_q <= hit_seen_q || jrsp.hit;
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					if (close_go) begin
						if (last_q) begin
							if (valid_seen_q) begin
								m_tvalid_q <= 1'b1;
								collision_q <= hit_seen_q;
							end
							hit_seen_q <= 1'b0;
							valid_seen_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(lspg_pkg::OUT_W - 1){1'b0}}, collision_q};

	// A judge result only arrives while the frame logic waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		jrsp.done |-> (state_q == ST_JUDGE))
		else $error("judge result outside the judge state");

	// A new result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten");

	// Closing a frame clears both sticky flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		(close_go && last_q) |=> (!hit_seen_q && !valid_seen_q))
		else $error("frame flags not cleared at frame end");

	// A hit implies a valid point was seen in the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		hit_seen_q |-> valid_seen_q)
		else $error("hit flag without a valid point");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the lidar sector proximity gate: directed and random point clouds.
`default_nettype none
module tb_top;
	import lspg_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// pos_x [15:0], pos_y [31:16], pos_z [47:32]
	logic [TDATA_W-1:0] s_tdata;
	// point_valid [0]
	logic [0:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	// collision [0]
	logic [OUT_W-1:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// Shadow copy of the block's registers and frame flags.
	logic [LIM_W-1:0] cfg_limit;
	logic [SINE_W-1:0] cfg_sine;
	logic frame_hit;
	logic frame_valid;
	// Collision flags still owed by the block, oldest first.
	logic collision_q[$];
	int mismatches;
	bit no_idle;

	lidar_sector_proximity_gate u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Magnitude of a two's complement coordinate; the most negative value maps to 32768.
	function automatic logic [63:0] coord_mag(input logic [COORD_WIDTH-1:0] raw);
		logic [COORD_WIDTH-1:0] neg;
		neg = ~raw + 1'b1;
		return raw[COORD_WIDTH-1] ? 64'(neg) : 64'(raw);
	endfunction

	// Sector test for one valid point: forward window, range sphere, pitch band.
	function automatic logic sector_hit(input logic [COORD_WIDTH-1:0] px, py, pz);
		logic [63:0] ax, ay, az, lim, d2, lhs, rhs;
		ax = coord_mag(px);
		ay = coord_mag(py);
		az = coord_mag(pz);
		lim = 64'(cfg_limit);
		if (px[COORD_WIDTH-1] || ax < 64'd1 || ax > lim)
			return 1'b0;
		if (ay >= lim || az >= lim)
			return 1'b0;
		d2 = ax * ax + ay * ay + az * az;
		if (d2 >= lim * lim)
			return 1'b0;
		lhs = (az * az) << 30;
		rhs = 64'(cfg_sine) * 64'(cfg_sine) * d2;
		return lhs <= rhs;
	endfunction

	// Random coordinate spread around +/- span, with some full-range noise and some values near zero.
	function automatic logic [COORD_WIDTH-1:0] rand_coord(input int span);
		int sel;
		sel = $urandom_range(0, 9);
		if (span > 32767)
			span = 32767;
		if (sel < 2)
			return COORD_WIDTH'($urandom());
		if (sel < 8)
			return COORD_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
		return COORD_WIDTH'(int'($urandom_range(0, 32)) - 16);
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s expected %0h actual %0h", what, want, got);
	endtask

	// Send one point request and update the predicted frame state when it is taken.
	task automatic send_point(input logic [COORD_WIDTH-1:0] px, py, pz, input logic vld,
			input logic lst);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 22) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pz, py, px};
		s_tuser <= vld;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (vld) begin
			frame_valid = 1'b1;
			if (sector_hit(px, py, pz))
				frame_hit = 1'b1;
		end
		if (lst) begin
			if (frame_valid)
				collision_q.push_back(frame_hit);
			frame_hit = 1'b0;
			frame_valid = 1'b0;
		end
	endtask

	// Let every owed result arrive, then give the block time to finish any point in flight.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (collision_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	// One APB write; bits above the register width carry random junk to check masking.
	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] val, input int width);
		logic [APB_DW-1:0] mask;
		mask = (APB_DW'(1) << width) - 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= (APB_DW'($urandom()) & ~mask) | (val & mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_DISTANCE_LIMIT)
			cfg_limit = LIM_W'(val);
		else
			cfg_sine = SINE_W'(val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_limits(input int lim, input int sine);
		wait_idle();
		write_reg(REG_DISTANCE_LIMIT, APB_DW'(lim), LIM_W);
		write_reg(REG_SINE_LIMIT, APB_DW'(sine), SINE_W);
	endtask

	// Window edges and coordinate extremes at the reset limits.
	task automatic test_default_sector();
		send_point(16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(-16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd199, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd200, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd100, 16'sd0, 16'sd12, 1'b1, 1'b1);
		send_point(16'sd100, 16'sd0, -16'sd13, 1'b1, 1'b1);
		send_point(16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1, 1'b1);
		send_point(16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
	endtask

	// Sticky flags across a frame, ignored points and an empty frame.
	task automatic test_frame_flags();
		send_point(16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b1);
		send_point(16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_point(16'sd150, 16'sd150, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd5, 16'sd0, 16'sd0, 1'b1, 1'b0);
		send_point(-16'sd5, 16'sd0, 16'sd0, 1'b1, 1'b0);
		send_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
	endtask

	// Zero limit, largest limit, and the sine at zero, one and its top code.
	task automatic test_limit_corners();
		apply_limits(0, 3993);
		send_point(16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
		apply_limits(32767, 65535);
		send_point(16'sd32766, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd32767, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd1, 16'sd0, 16'sd32000, 1'b1, 1'b1);
		apply_limits(200, 0);
		send_point(16'sd10, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_point(16'sd10, 16'sd0, 16'sd1, 1'b1, 1'b1);
		apply_limits(200, 32768);
		send_point(16'sd10, 16'sd0, 16'sd10, 1'b1, 1'b1);
	endtask

	// Random frames under one setting until about the given number of points is sent.
	task automatic run_random_frames(input int lim, input int sine, input int points);
		int count, len, span;
		bit blank;
		logic vld;
		logic [COORD_WIDTH-1:0] px, pz;
		apply_limits(lim, sine);
		span = lim + lim / 4 + 2;
		count = 0;
		while (count < points) begin
			len = $urandom_range(1, 6);
			blank = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++) begin
				vld = !blank && ($urandom_range(0, 99) < 85);
				if ($urandom_range(0, 3) != 0)
					px = COORD_WIDTH'($urandom_range(0, (span > 32767) ? 32767 : span));
				else
					px = rand_coord(span);
				pz = rand_coord(span >> $urandom_range(0, 4));
				send_point(px, rand_coord(span), pz, vld, i == len - 1);
				count++;
			end
		end
	endtask

	task automatic test_random_sweep();
		run_random_frames(200, 3993, 70);
		run_random_frames(0, $urandom_range(0, 65535), 60);
		no_idle = 1'b1;
		run_random_frames(32767, 32768, 70);
		no_idle = 1'b0;
		run_random_frames($urandom_range(1, 2000), 65535, 70);
		run_random_frames($urandom_range(1, 32767), 0, 60);
		run_random_frames($urandom_range(1, 32767), $urandom_range(0, 65535), 80);
		run_random_frames($urandom_range(1, 300), $urandom_range(2000, 12000), 80);
	endtask

	// Result side: random back-pressure, none during the quiet stretch.
	always @(posedge clk)
		m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 22);

	// Compare every result request with the oldest owed collision flag.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (collision_q.size() == 0)
				report_mismatch("unexpected result", '0, m_tdata);
			else if (m_tdata != OUT_W'(collision_q[0]))
				report_mismatch("collision", OUT_W'(collision_q.pop_front()), m_tdata);
			else
				void'(collision_q.pop_front());
		end
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_limit = DISTANCE_LIMIT_RST;
		cfg_sine = SINE_LIMIT_RST;
		frame_hit = 1'b0;
		frame_valid = 1'b0;
		mismatches = 0;
		no_idle = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (64) @(posedge clk);

		test_default_sector();
		test_frame_flags();
		test_limit_corners();
		test_random_sweep();

		wait_idle();
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire
